// File: rtl/scan_nearest_target_follower_top_macros.svh
// assertion macros shared by the checker of scan_nearest_target_follower_top
// no dependencies; included by snf_checker.sv
`ifndef SCAN_NEAREST_TARGET_FOLLOWER_TOP_MACROS_SVH
`define SCAN_NEAREST_TARGET_FOLLOWER_TOP_MACROS_SVH

// checked only while out of reset
`define SNF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("snf assertion failed");

// checked at every edge, reset included
`define SNF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("snf reset assertion failed");

`endif

// File: rtl/snf_pkg.sv
// types, constants and register codes of the nearest target follower
// no dependencies; used by every other file of the block but the macros header
`default_nettype none
package snf_pkg;

  localparam int unsigned RangeW  = 16;
  localparam int unsigned AngleW  = 20;
  localparam int unsigned StartW  = 19;
  localparam int unsigned StepW   = 16;
  localparam int unsigned SpeedW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 19;

  localparam logic [RangeW-1:0]        MAX_RANGE_RST = 16'hFFFF;
  localparam logic [6:0]               SPEED_NUM     = 7'd77;
  localparam logic [14:0]              TWO_Q88       = 15'd512;
  localparam logic [14:0]              THREE_Q88     = 15'd768;
  localparam logic [SpeedW-1:0]        ONE_Q88       = 16'd256;
  localparam logic [RangeW-1:0]        TWO_Q88_DIST  = 16'd512;
  localparam logic signed [AngleW-1:0] DEAD_BAND     = 20'sd1966;
  localparam logic signed [AngleW-1:0] ANGLE_MAX     = 20'sd524287;
  localparam logic signed [AngleW-1:0] ANGLE_FLOOR   = -20'sd524288;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_RANGE   = 2'd0,
    CFG_START_ANGLE = 2'd1,
    CFG_ANGLE_STEP  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [RangeW-1:0]        max_range;
    logic signed [StartW-1:0] start_angle;
    logic [StepW-1:0]         angle_step;
  } snf_cfg_t;

  typedef struct packed {
    logic [RangeW-1:0]        distance;
    logic signed [AngleW-1:0] angle;
  } snf_near_t;

endpackage
`default_nettype wire

// File: rtl/snf_in_if.sv
// input channel: one range sample per item
// depends on snf_pkg
`default_nettype none
interface snf_in_if import snf_pkg::*;;
  logic              valid;
  logic              ready;
  logic [RangeW-1:0] range_sample;
  logic              last_sample;

  modport source (output valid, output range_sample, output last_sample, input ready);
  modport sink   (input valid, input range_sample, input last_sample, output ready);
endinterface
`default_nettype wire

// File: rtl/snf_out_if.sv
// result channel: one drive command per scan
// depends on snf_pkg
`default_nettype none
interface snf_out_if import snf_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [SpeedW-1:0]        linear_speed;
  logic signed [AngleW-1:0] turn_rate;

  modport source (output valid, output linear_speed, output turn_rate, input ready);
  modport sink   (input valid, input linear_speed, input turn_rate, output ready);
endinterface
`default_nettype wire

// File: rtl/snf_cfg_if.sv
// configuration write channel: register index and write data
// depends on snf_pkg
`default_nettype none
interface snf_cfg_if import snf_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/snf_track.sv
// per-scan state: nearest distance, its angle and the beam angle accumulator
// depends on snf_pkg
`default_nettype none
module snf_track import snf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire snf_cfg_t          cfg,
  input  wire logic              fire,
  input  wire logic [RangeW-1:0] sample,
  input  wire logic              last,
  output snf_near_t              near_upd
);

  logic [RangeW-1:0]        dist_r;
  logic signed [AngleW-1:0] near_ang_r;
  logic signed [AngleW-1:0] cur_ang_r;
  logic signed [AngleW-1:0] cur_ang_nxt;
  logic signed [AngleW:0]   ang_sum;

  // strict compare keeps the first sample on ties
  always_comb begin
    if (sample < dist_r) begin
      near_upd.distance = sample;
      near_upd.angle    = cur_ang_r;
    end else begin
      near_upd.distance = dist_r;
      near_upd.angle    = near_ang_r;
    end
  end

  // step is never negative, so only the upper end saturates
  assign ang_sum     = {cur_ang_r[AngleW-1], cur_ang_r} + $signed({1'b0, 4'b0, cfg.angle_step});
  assign cur_ang_nxt = (ang_sum > $signed({ANGLE_MAX[AngleW-1], ANGLE_MAX})) ? ANGLE_MAX
                                                                             : ang_sum[AngleW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r     <= MAX_RANGE_RST;
      near_ang_r <= '0;
      cur_ang_r  <= '0;
    end else if (fire) begin
      if (last) begin
        // rearm for the next scan
        dist_r     <= cfg.max_range;
        near_ang_r <= '0;
        cur_ang_r  <= {cfg.start_angle[StartW-1], cfg.start_angle};
      end else begin
        dist_r     <= near_upd.distance;
        near_ang_r <= near_upd.angle;
        cur_ang_r  <= cur_ang_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/snf_cmd.sv
// drive command from the nearest target: linear speed and turn rate
// depends on snf_pkg
`default_nettype none
module snf_cmd import snf_pkg::*; (
  input  wire snf_near_t              near,
  input  wire logic [RangeW-1:0]      max_range,
  output logic [SpeedW-1:0]           linear_speed,
  output logic signed [AngleW-1:0]    turn_rate
);

  logic [22:0]              prod;
  logic [14:0]              speed_raw;
  logic signed [AngleW+1:0] neg_dbl;
  logic                     dead;

  // 0.3 taken as 77/256
  assign prod      = 23'(near.distance) * 23'(SPEED_NUM);
  assign speed_raw = prod[22:8];

  always_comb begin
    if (near.distance >= max_range || near.distance < TWO_Q88_DIST) begin
      linear_speed = '0;
    end else if (speed_raw > TWO_Q88 && speed_raw < THREE_Q88) begin
      linear_speed = ONE_Q88;
    end else begin
      linear_speed = {1'b0, speed_raw};
    end
  end

  assign dead    = (near.angle >= -DEAD_BAND) && (near.angle <= DEAD_BAND);
  assign neg_dbl = -$signed({near.angle[AngleW-1], near.angle, 1'b0});

  always_comb begin
    if (dead) begin
      turn_rate = '0;
    end else if (neg_dbl > $signed({{2{ANGLE_MAX[AngleW-1]}}, ANGLE_MAX})) begin
      turn_rate = ANGLE_MAX;
    end else if (neg_dbl < $signed({{2{ANGLE_FLOOR[AngleW-1]}}, ANGLE_FLOOR})) begin
      turn_rate = ANGLE_FLOOR;
    end else begin
      turn_rate = neg_dbl[AngleW-1:0];
    end
  end

endmodule
`default_nettype wire

// File: rtl/scan_nearest_target_follower_top.sv
// nearest target follower: input register, tracking/command logic, result register
// flow: a last sample is taken into the input register, the command is loaded into the
//   result register when that sample leaves it and shown from then on until taken
// throughput: one sample per cycle; a last sample waits on an untaken result
// reset: config back to defaults, tracking state rearmed, both registers empty
// depends on snf_pkg, snf_in_if, snf_out_if, snf_cfg_if, snf_track, snf_cmd
`default_nettype none
module scan_nearest_target_follower_top import snf_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  snf_in_if.sink   in_if,
  snf_out_if.source out_if,
  snf_cfg_if.sink  cfg_if
);

  snf_cfg_t                 cfg_r;
  logic                     s1_valid_r;
  logic [RangeW-1:0]        s1_sample_r;
  logic                     s1_last_r;
  logic                     out_valid_r;
  logic [SpeedW-1:0]        out_speed_r;
  logic signed [AngleW-1:0] out_turn_r;

  logic                     out_free;
  logic                     s1_fire;
  logic                     in_acc;
  snf_near_t                near_upd;
  logic [SpeedW-1:0]        speed_c;
  logic signed [AngleW-1:0] turn_c;

  // configuration registers
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_range   <= MAX_RANGE_RST;
      cfg_r.start_angle <= '0;
      cfg_r.angle_step  <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_MAX_RANGE:   cfg_r.max_range   <= cfg_if.data[RangeW-1:0];
        CFG_START_ANGLE: cfg_r.start_angle <= $signed(cfg_if.data[StartW-1:0]);
        CFG_ANGLE_STEP:  cfg_r.angle_step  <= cfg_if.data[StepW-1:0];
        default: ;
      endcase
    end
  end

  // a non-last item leaves no result, so it never waits on the output side
  assign out_free    = !out_valid_r || out_if.ready;
  assign s1_fire     = s1_valid_r && (!s1_last_r || out_free);
  assign in_if.ready = !s1_valid_r || s1_fire;
  assign in_acc      = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_if.range_sample;
      s1_last_r   <= in_if.last_sample;
    end
  end

  snf_track u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .fire     (s1_fire),
    .sample   (s1_sample_r),
    .last     (s1_last_r),
    .near_upd (near_upd)
  );

  snf_cmd u_cmd (
    .near         (near_upd),
    .max_range    (cfg_r.max_range),
    .linear_speed (speed_c),
    .turn_rate    (turn_c)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_speed_r <= speed_c;
      out_turn_r  <= turn_c;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.linear_speed = out_speed_r;
  assign out_if.turn_rate    = out_turn_r;

endmodule
`default_nettype wire

// File: rtl/snf_checker.sv
// port-level checks of scan_nearest_target_follower_top and its bind
// depends on snf_pkg and scan_nearest_target_follower_top_macros.svh
`default_nettype none
`include "scan_nearest_target_follower_top_macros.svh"
module snf_port_checker import snf_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic [SpeedW-1:0]        linear_speed,
  input wire logic signed [AngleW-1:0] turn_rate
);

  // a held command keeps its value
  `SNF_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(linear_speed) && $stable(turn_rate))

  // speed is zero, the fixed 1.0, or a scaled distance outside the (2,3) band
  `SNF_ASSERT(a_speed_set, clk, rst_n, out_valid |-> linear_speed == 16'd0 || linear_speed == 16'd256 || (linear_speed >= 16'd153 && linear_speed <= 16'd512) || linear_speed >= 16'd768)

  // reset empties the result register and opens the input
  `SNF_ASSERT_ALWAYS(a_rst_out, clk, !rst_n |=> !out_valid)
  `SNF_ASSERT_ALWAYS(a_rst_in, clk, !rst_n |=> in_ready)

endmodule

bind scan_nearest_target_follower_top snf_port_checker u_snf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .linear_speed (out_if.linear_speed),
  .turn_rate    (out_if.turn_rate)
);
`default_nettype wire
